// ----- hdl/device_address_table_with_aging_top_assert.svh -----
// Assertion macros shared by the device address table modules.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DEVICE_ADDRESS_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define DEVICE_ADDRESS_TABLE_WITH_AGING_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define DAT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dat: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define DAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dat: next-cycle check failed");

`endif

// ----- hdl/dat_pkg.sv -----
// Shared types and constants for the device address table with aging.
// No dependencies; imported by every module of the block.
package dat_pkg;

  localparam int TABLE_SLOTS = 16;
  // slot index width; equals the width of entry_index and result_index
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int ADDR_W      = 48;
  localparam int STR_W       = 8;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    ACT_OBSERVE = 2'd0,
    ACT_WSTR    = 2'd1,
    ACT_SWEEP   = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef struct packed {
    action_t                  action;
    logic [ADDR_W-1:0]        device_address;
    logic [SLOT_W-1:0]        entry_index;
    logic signed [STR_W-1:0]  signal_strength;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]        result_index;
    logic                     index_valid;
    logic                     newly_added;
    logic                     removed_any;
    logic                     slot_occupied;
    logic [ADDR_W-1:0]        address_out;
    logic signed [STR_W-1:0]  strength_out;
    logic [CNT_W-1:0]         device_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_WSTR,
    S_SWEEP,
    S_RDREQ,
    S_RDCAP,
    S_DONE
  } seq_state_t;

  // sequencer -> table storage
  typedef struct packed {
    logic                    addr_we;
    logic [SLOT_W-1:0]       addr_wa;
    logic [ADDR_W-1:0]       addr_wd;
    logic                    str_we;
    logic [SLOT_W-1:0]       str_wa;
    logic [STR_W-1:0]        str_wd;
    logic [SLOT_W-1:0]       rd_a;
    logic                    fill;
    logic                    erase;
    logic                    mark;
    logic                    unmark;
    logic [SLOT_W-1:0]       flag_a;
  } st_cmd_t;

  // table storage -> sequencer
  typedef struct packed {
    logic [TABLE_SLOTS-1:0]  used;
    logic [TABLE_SLOTS-1:0]  seen;
    logic [TABLE_SLOTS-1:0]  str_vld;
    logic [ADDR_W-1:0]       addr_rd;
    logic [STR_W-1:0]        str_rd;
  } st_stat_t;

endpackage

// ----- hdl/dat_store.sv -----
// Table storage: address and strength memories plus per-slot flag bits.
// Depends on dat_pkg.
module dat_store import dat_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  st_cmd_t  cmd,
  output st_stat_t stat
);

  logic [ADDR_W-1:0]      addr_mem [TABLE_SLOTS];
  logic [STR_W-1:0]       str_mem  [TABLE_SLOTS];
  logic [ADDR_W-1:0]      addr_rd_r;
  logic [STR_W-1:0]       str_rd_r;
  logic [TABLE_SLOTS-1:0] used_r;
  logic [TABLE_SLOTS-1:0] seen_r;
  logic [TABLE_SLOTS-1:0] str_vld_r;

  // memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.addr_we) begin
      addr_mem[cmd.addr_wa] <= cmd.addr_wd;
    end
    if (cmd.str_we) begin
      str_mem[cmd.str_wa] <= cmd.str_wd;
    end
    addr_rd_r <= addr_mem[cmd.rd_a];
    str_rd_r  <= str_mem[cmd.rd_a];
  end

  // flag bits; str_vld is clear for a strength entry never written or erased
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      seen_r    <= '0;
      str_vld_r <= '0;
    end else begin
      if (cmd.fill) begin
        used_r[cmd.flag_a] <= 1'b1;
        seen_r[cmd.flag_a] <= 1'b1;
      end
      if (cmd.erase) begin
        used_r[cmd.flag_a]    <= 1'b0;
        seen_r[cmd.flag_a]    <= 1'b0;
        str_vld_r[cmd.flag_a] <= 1'b0;
      end
      if (cmd.mark) begin
        seen_r[cmd.flag_a] <= 1'b1;
      end
      if (cmd.unmark) begin
        seen_r[cmd.flag_a] <= 1'b0;
      end
      if (cmd.str_we) begin
        str_vld_r[cmd.str_wa] <= 1'b1;
      end
    end
  end

  assign stat.used    = used_r;
  assign stat.seen    = seen_r;
  assign stat.str_vld = str_vld_r;
  assign stat.addr_rd = addr_rd_r;
  assign stat.str_rd  = str_rd_r;

endmodule

// ----- hdl/dat_seq.sv -----
// Sequencer: walks the slots one per cycle with a shared address comparator
// and a shared count adder. Depends on dat_pkg and the assertion header.
`include "device_address_table_with_aging_top_assert.svh"

module dat_seq import dat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      done,
  output out_item_t res,
  output st_cmd_t   cmd,
  input  st_stat_t  stat
);

  seq_state_t        state_r, state_nxt;
  in_item_t          cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0] cmp_ptr_r, cmp_ptr_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SLOT_W-1:0] free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  out_item_t         res_r, res_nxt;

  logic accept;
  logic hit;
  logic erase_now;
  logic cnt_inc;
  logic cnt_dec;
  logic [SLOT_W-1:0] idx;

  assign accept = start && (state_r == S_IDLE);
  assign idx    = cmd_r.entry_index;

  // shared comparator: stored address of the slot read last cycle
  assign hit = (state_r == S_SCAN) && cmp_vld_r && stat.used[cmp_ptr_r] &&
               (stat.addr_rd == cmd_r.device_address);

  assign erase_now = (state_r == S_SWEEP) && stat.used[ptr_r] && !stat.seen[ptr_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_OBSERVE: state_nxt = S_SCAN;
            ACT_WSTR:    state_nxt = S_WSTR;
            ACT_SWEEP:   state_nxt = S_SWEEP;
            ACT_READ:    state_nxt = S_RDREQ;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_DONE;
        end else if (cmp_vld_r && (cmp_ptr_r == LAST_SLOT)) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL:  state_nxt = S_DONE;
      S_WSTR:  state_nxt = S_DONE;
      S_SWEEP: begin
        if (ptr_r == LAST_SLOT) begin
          state_nxt = S_DONE;
        end
      end
      S_RDREQ: state_nxt = S_RDCAP;
      S_RDCAP: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: storage commands and handshake
  always_comb begin
    cmd         = '0;
    cmd.rd_a    = (state_r == S_RDREQ) ? idx : ptr_r;
    cmd.addr_wa = free_idx_r;
    cmd.addr_wd = cmd_r.device_address;
    cmd.str_wa  = idx;
    cmd.str_wd  = cmd_r.signal_strength;
    cmd.flag_a  = ptr_r;
    case (state_r)
      S_SCAN: begin
        cmd.mark   = hit;
        cmd.flag_a = cmp_ptr_r;
      end
      S_FILL: begin
        cmd.fill    = free_found_r;
        cmd.addr_we = free_found_r;
        cmd.flag_a  = free_idx_r;
      end
      S_WSTR: begin
        cmd.str_we = 1'b1;
      end
      S_SWEEP: begin
        cmd.erase  = erase_now;
        cmd.unmark = stat.used[ptr_r] && stat.seen[ptr_r];
      end
      default: begin
      end
    endcase
    busy = (state_r != S_IDLE);
    done = (state_r == S_DONE);
  end

  // shared count adder
  assign cnt_inc = (state_r == S_FILL) && free_found_r;
  assign cnt_dec = erase_now;

  always_comb begin
    count_nxt = count_r;
    if (cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // datapath registers
  always_comb begin
    cmd_nxt        = cmd_r;
    ptr_nxt        = ptr_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_ptr_nxt    = cmp_ptr_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_nxt        = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_item;
          ptr_nxt        = '0;
          cmp_vld_nxt    = 1'b0;
          free_found_nxt = 1'b0;
          res_nxt        = '0;
          res_nxt.result_index = (in_item.action == ACT_OBSERVE) ? '0 : in_item.entry_index;
        end
      end
      S_SCAN: begin
        ptr_nxt     = ptr_r + SLOT_W'(1);
        cmp_vld_nxt = 1'b1;
        cmp_ptr_nxt = ptr_r;
        // lowest free slot, remembered in case the lookup misses
        if (!free_found_r && !stat.used[ptr_r]) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = ptr_r;
        end
        if (hit) begin
          res_nxt.result_index = cmp_ptr_r;
          res_nxt.index_valid  = 1'b1;
        end
      end
      S_FILL: begin
        if (free_found_r) begin
          res_nxt.result_index = free_idx_r;
          res_nxt.index_valid  = 1'b1;
          res_nxt.newly_added  = 1'b1;
        end
      end
      S_SWEEP: begin
        ptr_nxt = ptr_r + SLOT_W'(1);
        if (erase_now) begin
          res_nxt.removed_any = 1'b1;
        end
      end
      S_RDCAP: begin
        // a free slot always reads back as a zero address
        res_nxt.slot_occupied = stat.used[idx];
        res_nxt.address_out   = stat.used[idx] ? stat.addr_rd : '0;
        res_nxt.strength_out  = stat.str_vld[idx] ? stat.str_rd : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ptr_r        <= ptr_nxt;
    cmp_vld_r    <= cmp_vld_nxt;
    cmp_ptr_r    <= cmp_ptr_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_r        <= res_nxt;
  end

  always_comb begin
    res              = res_r;
    res.device_count = count_r;
  end

  // count tracks the occupied bits exactly
  `DAT_ASSERT_SAME(a_count_matches, 1'b1, count_r == CNT_W'($countones(stat.used)))
  // a fill only ever lands on a free slot
  `DAT_ASSERT_SAME(a_fill_free, state_r == S_FILL && free_found_r, !stat.used[free_idx_r])
  // an accepted beat keeps the block busy in the next cycle
  `DAT_ASSERT_NEXT(a_accept_busy, accept, busy)
  // newly added implies a valid index
  `DAT_ASSERT_SAME(a_new_valid, done && res.newly_added, res.index_valid)

endmodule

// ----- hdl/device_address_table_with_aging_top.sv -----
// Top level of the device address table with aging.
// Depends on dat_pkg, dat_store and dat_seq.

// A 16-slot table of 48-bit device addresses with seen marks for aging.
// Drive start with a beat on in_data while busy is low; the block then
// holds busy high until it is done and shows the result on out_data for
// exactly one cycle with out_valid high. The receiver cannot stall, so
// capture out_data whenever out_valid is set. An observe walks the slots
// one per cycle through the shared address comparator behind the
// registered memory read and stops on a hit; on a miss or a full table it
// scans all slots, then fills a free slot if there is one. A sweep walks
// every slot one per cycle. A new beat may be started in the cycle the
// result is shown.
module device_address_table_with_aging_top import dat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  st_cmd_t   st_cmd;
  st_stat_t  st_stat;
  logic      seq_done;
  out_item_t seq_res;
  logic      out_valid_r;
  out_item_t out_data_r;

  dat_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_data),
    .busy    (busy),
    .done    (seq_done),
    .res     (seq_res),
    .cmd     (st_cmd),
    .stat    (st_stat)
  );

  dat_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (st_cmd),
    .stat  (st_stat)
  );

  // result register: one-cycle strobe per finished beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= seq_done;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_data_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
